>>> rtl/tbpd_pkg.sv
// Shared types, constants and the button region table for the touch button detector.
// Used by tbpd_cell, tbpd_ctrl and touch_button_press_detector_unit; no dependencies.
`default_nettype none

package tbpd_pkg;

    localparam int TABLE_LEN  = 8;
    localparam int PANEL_SIZE = 720;
    localparam int IN_W       = 10;
    localparam int PT_W       = 13;
    localparam int DX_W       = PT_W + 1;
    localparam int SQ_W       = 2 * DX_W;
    localparam int SUM_W      = SQ_W + 1;
    localparam int BIDX_W     = 3;
    localparam int CFG_IDX_W  = 2;

    localparam logic OP_POINT = 1'b0;
    localparam logic OP_EOF   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SWAP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_H = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_V = 2'd2;

    localparam bit REGION_ROUND [0:TABLE_LEN-1] = '{0, 0, 1, 1, 1, 1, 1, 1};
    localparam int REGION_CX    [0:TABLE_LEN-1] = '{90, 90, 440, 548, 656, 250, 220, 300};
    localparam int REGION_CY    [0:TABLE_LEN-1] = '{588, 682, 632, 632, 624, 590, 682, 682};
    localparam int REGION_HW    [0:TABLE_LEN-1] = '{64, 64, 46, 46, 60, 44, 30, 30};
    localparam int REGION_HH    [0:TABLE_LEN-1] = '{36, 32, 0, 0, 0, 0, 0, 0};

    typedef struct packed {
        logic                   valid;
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
    } pt_t;

    typedef struct packed {
        logic cur;
        logic prev;
    } btn_state_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_SCAN
    } ctrl_state_t;

endpackage

`default_nettype wire

>>> rtl/tbpd_cell.sv
// One button cell: hit-tests the passing point against its region and holds its hit bits.
// Depends on tbpd_pkg; chained by touch_button_press_detector_unit.
`default_nettype none

module tbpd_cell
    import tbpd_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire pt_t        pt_in,
    input  wire logic       commit,
    output pt_t             pt_out,
    output btn_state_t      btn_state
);

    localparam bit                     ROUND = REGION_ROUND[IDX];
    localparam logic signed [DX_W-1:0] CX    = DX_W'(REGION_CX[IDX]);
    localparam logic signed [DX_W-1:0] CY    = DX_W'(REGION_CY[IDX]);
    localparam logic        [DX_W-1:0] HW    = DX_W'(REGION_HW[IDX]);
    localparam logic        [DX_W-1:0] HH    = DX_W'(REGION_HH[IDX]);
    localparam logic        [SUM_W-1:0] R2   = SUM_W'(REGION_HW[IDX] * REGION_HW[IDX]);

    pt_t                     pt_reg;
    logic                    sq_valid_reg;
    logic [SQ_W-1:0]         sqx_reg, sqx_next;
    logic [SQ_W-1:0]         sqy_reg, sqy_next;
    logic                    rect_ok_reg, rect_ok_next;
    logic                    cur_reg, cur_next;
    logic                    prev_reg, prev_next;

    logic signed [DX_W-1:0]  dx, dy;
    logic        [DX_W-1:0]  adx, ady;
    logic signed [SQ_W-1:0]  px2, py2;
    logic        [SUM_W-1:0] dist2;
    logic                    hit;

    always_comb
    begin
        dx           = {pt_in.x[PT_W-1], pt_in.x} - CX;
        dy           = {pt_in.y[PT_W-1], pt_in.y} - CY;
        adx          = dx[DX_W-1] ? DX_W'(-dx) : dx;
        ady          = dy[DX_W-1] ? DX_W'(-dy) : dy;
        px2          = SQ_W'(dx) * SQ_W'(dx);
        py2          = SQ_W'(dy) * SQ_W'(dy);
        sqx_next     = px2;
        sqy_next     = py2;
        rect_ok_next = (adx <= HW) && (ady <= HH);

        dist2 = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        hit   = ROUND ? (dist2 <= R2) : rect_ok_reg;

        cur_next  = cur_reg | (sq_valid_reg & hit);
        prev_next = prev_reg;
        if (commit)
        begin
            prev_next = cur_reg;
            cur_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_reg       <= '0;
            sq_valid_reg <= 1'b0;
            cur_reg      <= 1'b0;
            prev_reg     <= 1'b0;
        end
        else
        begin
            pt_reg       <= pt_in;
            sq_valid_reg <= pt_in.valid;
            cur_reg      <= cur_next;
            prev_reg     <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sqx_reg     <= sqx_next;
        sqy_reg     <= sqy_next;
        rect_ok_reg <= rect_ok_next;
    end

    assign pt_out         = pt_reg;
    assign btn_state.cur  = cur_reg;
    assign btn_state.prev = prev_reg;

endmodule

`default_nettype wire

>>> rtl/tbpd_ctrl.sv
// Controller: config registers, point remap and injection, drain wait and event scan.
// Depends on tbpd_pkg; drives the cell chain in touch_button_press_detector_unit.
`default_nettype none

module tbpd_ctrl
    import tbpd_pkg::*;
#(
    parameter int NUM_CELLS = 8
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic                       cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       operation,
    input  wire logic [IN_W-1:0]            touch_x,
    input  wire logic [IN_W-1:0]            touch_y,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [BIDX_W-1:0]               button_index,
    output logic                            pressed,
    output logic                            last,
    output pt_t                             inj,
    output logic                            commit,
    input  wire btn_state_t [NUM_CELLS-1:0] btn_state
);

    localparam int IDX_W  = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int CNT_W  = $clog2(NUM_CELLS + 2);
    localparam logic [CNT_W-1:0] DRAIN_INIT = CNT_W'(NUM_CELLS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(NUM_CELLS - 1);
    localparam logic signed [PT_W-1:0] MAX_C = PT_W'(PANEL_SIZE - 1);

    ctrl_state_t        state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   drain_reg, drain_next;
    pt_t                inj_reg, inj_next;
    logic               swap_reg, mirror_h_reg, mirror_v_reg;
    logic               out_valid_reg, out_valid_next;
    logic [BIDX_W-1:0]  out_idx_reg, out_idx_next;
    logic               out_pressed_reg, out_pressed_next;
    logic               out_last_reg, out_last_next;

    logic [NUM_CELLS-1:0] cur_vec, changed, later;
    logic signed [PT_W-1:0] sx, sy, rx, ry;
    logic                 slot_free, load;

    always_comb
    begin
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            cur_vec[i] = btn_state[i].cur;
            changed[i] = btn_state[i].cur ^ btn_state[i].prev;
        end
        later[NUM_CELLS-1] = 1'b0;
        for (int i = NUM_CELLS - 2; i >= 0; i--)
        begin
            later[i] = later[i+1] | changed[i+1];
        end
    end

    always_comb
    begin
        sx = swap_reg ? PT_W'(touch_y) : PT_W'(touch_x);
        sy = swap_reg ? PT_W'(touch_x) : PT_W'(touch_y);
        rx = mirror_h_reg ? MAX_C - sx : sx;
        ry = mirror_v_reg ? MAX_C - sy : sy;
    end

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        drain_next       = (drain_reg != '0) ? drain_reg - 1'b1 : drain_reg;
        inj_next         = inj_reg;
        inj_next.valid   = 1'b0;
        commit           = 1'b0;
        load             = 1'b0;
        in_ready         = (state_reg == ST_IDLE);
        slot_free        = !out_valid_reg || out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == OP_POINT)
                    begin
                        inj_next.valid = 1'b1;
                        inj_next.x     = rx;
                        inj_next.y     = ry;
                        drain_next     = DRAIN_INIT;
                    end
                    else
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg == '0)
                begin
                    state_next = ST_SCAN;
                    idx_next   = '0;
                end
            end
            ST_SCAN:
            begin
                if (!changed[idx_reg] || slot_free)
                begin
                    load = changed[idx_reg];
                    if (idx_reg == LAST_IDX)
                    begin
                        commit     = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next   = (out_valid_reg && !out_ready) || load;
        out_idx_next     = out_idx_reg;
        out_pressed_next = out_pressed_reg;
        out_last_next    = out_last_reg;
        if (load)
        begin
            out_idx_next     = BIDX_W'(idx_reg);
            out_pressed_next = cur_vec[idx_reg];
            out_last_next    = !later[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            drain_reg     <= '0;
            inj_reg       <= '0;
            out_valid_reg <= 1'b0;
            swap_reg      <= 1'b0;
            mirror_h_reg  <= 1'b0;
            mirror_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            drain_reg     <= drain_next;
            inj_reg       <= inj_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SWAP:     swap_reg     <= cfg_data;
                    CFG_MIRROR_H: mirror_h_reg <= cfg_data;
                    CFG_MIRROR_V: mirror_v_reg <= cfg_data;
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_idx_reg     <= out_idx_next;
        out_pressed_reg <= out_pressed_next;
        out_last_reg    <= out_last_next;
    end

    assign inj          = inj_reg;
    assign out_valid    = out_valid_reg;
    assign button_index = out_idx_reg;
    assign pressed      = out_pressed_reg;
    assign last         = out_last_reg;

`ifndef ASSERT_OFF
    a_commit_drained: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> (drain_reg == '0))
        else $error("commit while points still in the chain");

    a_commit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (cur_vec == '0))
        else $error("current hits not cleared after commit");

    a_no_inject_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !inj_reg.valid)
        else $error("point injected during event scan");

    a_word_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_SCAN))
        else $error("output word loaded outside the scan");
`endif

endmodule

`default_nettype wire

>>> rtl/touch_button_press_detector_unit.sv
// Top level of the touch button press detector: controller plus a chain of button cells.
// Depends on tbpd_pkg, tbpd_cell and tbpd_ctrl.
//
// Input channel (in_valid/in_ready): one word per touch point (operation = 0) or an
// end-of-frame marker (operation = 1). Touch points are taken one per cycle; each is
// remapped and then walks the cell chain, one cell per cycle, with a hit test in every
// cell that registers the offset check before it sets the hit bit.
// End of frame waits for the last point to drain from the chain, then scans the
// buttons one per cycle and emits a word for each changed button on the output
// channel (out_valid/out_ready), in button order, last set on the final one.
// The input stays not ready from end of frame until the scan finishes.
// A stalled receiver holds the scan on the next changed button; the output register
// keeps its word until taken.
// Configuration (cfg_we, cfg_index, cfg_data) sets axis swap and mirroring; write it
// only while idle.
// Reset clears configuration, both hit masks and all in-flight points; no clearing pass.
`default_nettype none

module touch_button_press_detector_unit
    import tbpd_pkg::*;
#(
    parameter int NUM_BUTTONS = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic                 cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 operation,
    input  wire logic [IN_W-1:0]      touch_x,
    input  wire logic [IN_W-1:0]      touch_y,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [BIDX_W-1:0]         button_index,
    output logic                      pressed,
    output logic                      last
);

    localparam int NUM_CELLS = (NUM_BUTTONS < TABLE_LEN) ? NUM_BUTTONS : TABLE_LEN;

    pt_t                        chain [0:NUM_CELLS-1];
    btn_state_t [NUM_CELLS-1:0] btn_state;
    logic                       commit;

    tbpd_ctrl #(
        .NUM_CELLS (NUM_CELLS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .touch_x      (touch_x),
        .touch_y      (touch_y),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .button_index (button_index),
        .pressed      (pressed),
        .last         (last),
        .inj          (chain[0]),
        .commit       (commit),
        .btn_state    (btn_state)
    );

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        if (i < NUM_CELLS - 1)
        begin : g_mid
            tbpd_cell #(
                .IDX (i)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .pt_in     (chain[i]),
                .commit    (commit),
                .pt_out    (chain[i+1]),
                .btn_state (btn_state[i])
            );
        end
        else
        begin : g_end
            tbpd_cell #(
                .IDX (i)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .pt_in     (chain[i]),
                .commit    (commit),
                .pt_out    (),
                .btn_state (btn_state[i])
            );
        end
    end

endmodule

`default_nettype wire
